// File: hw/rtl/cdll_pkg.sv
// shared types, codes and defaults of the cursor linked list
package cdll_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int REQ_W          = 4;
	localparam int VAL_W          = 32;
	localparam int LEN_W          = 9;
	localparam int OUT_W          = 120;

	typedef enum logic [3:0] {
		OP_PREPEND    = 4'd0,
		OP_APPEND     = 4'd1,
		OP_INS_BEFORE = 4'd2,
		OP_INS_AFTER  = 4'd3,
		OP_DEL_CURSOR = 4'd4,
		OP_DEL_FRONT  = 4'd5,
		OP_DEL_BACK   = 4'd6,
		OP_MV_FRONT   = 4'd7,
		OP_MV_BACK    = 4'd8,
		OP_MV_PREV    = 4'd9,
		OP_MV_NEXT    = 4'd10,
		OP_SET        = 4'd11,
		OP_CLEAR      = 4'd12,
		OP_QUERY      = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_CUR_UNDEF = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LRD_FHEAD = 2'd0,
		LRD_CUR   = 2'd1,
		LRD_REM   = 2'd2
	} lnk_sel_t;

	typedef enum logic [1:0] {
		VRD_HEAD = 2'd0,
		VRD_TAIL = 2'd1,
		VRD_CUR  = 2'd2
	} vrd_sel_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_DECODE,
		ACT_ALLOC,
		ACT_LINK1,
		ACT_LINK2,
		ACT_RM1,
		ACT_RM2,
		ACT_MOVE,
		ACT_CAP_HEAD,
		ACT_CAP_TAIL,
		ACT_LOAD
	} act_t;

	typedef struct packed {
		act_t     act;
		lnk_sel_t lnk_rd;
		vrd_sel_t val_rd;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic err;
		logic at_end;
	} dp_stat_t;

endpackage

// File: hw/rtl/cdll_ram.sv
// generic single write port ram with registered read
module cdll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/cdll_ctrl.sv
// sequencer for the cursor linked list
module cdll_ctrl
	import cdll_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     out_full,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_ALLOC, S_LNK1, S_LNK2, S_RM1, S_RM2, S_MOVE,
		S_RDH, S_RDT, S_RDC, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   can_load;

	assign can_load = !out_full || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.act    = ACT_NONE;
		cmd.lnk_rd = LRD_CUR;
		cmd.val_rd = VRD_CUR;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.act = ACT_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.act = ACT_DECODE;
				state_d = S_RDH;
				case (stat.op)
					OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
						cmd.lnk_rd = LRD_FHEAD;
						if (!stat.err) state_d = S_ALLOC;
					end
					OP_DEL_CURSOR, OP_DEL_FRONT, OP_DEL_BACK: begin
						cmd.lnk_rd = LRD_REM;
						if (!stat.err) state_d = S_RM1;
					end
					OP_MV_PREV, OP_MV_NEXT: begin
						if (!stat.err && !stat.at_end) state_d = S_MOVE;
					end
					default: state_d = S_RDH;
				endcase
			end
			S_ALLOC: begin
				cmd.act = ACT_ALLOC;
				state_d = S_LNK1;
			end
			S_LNK1: begin
				cmd.act = ACT_LINK1;
				if (stat.op == OP_INS_BEFORE || stat.op == OP_INS_AFTER) state_d = S_LNK2;
				else state_d = S_RDH;
			end
			S_LNK2: begin
				cmd.act = ACT_LINK2;
				state_d = S_RDH;
			end
			S_RM1: begin
				cmd.act = ACT_RM1;
				state_d = S_RM2;
			end
			S_RM2: begin
				cmd.act = ACT_RM2;
				state_d = S_RDH;
			end
			S_MOVE: begin
				cmd.act = ACT_MOVE;
				state_d = S_RDH;
			end
			S_RDH: begin
				cmd.val_rd = VRD_HEAD;
				state_d    = S_RDT;
			end
			S_RDT: begin
				cmd.val_rd = VRD_TAIL;
				cmd.act    = ACT_CAP_HEAD;
				state_d    = S_RDC;
			end
			S_RDC: begin
				cmd.act = ACT_CAP_TAIL;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (can_load) begin
					cmd.act = ACT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/cdll_dp.sv
// list registers, link and value memories, result register
module cdll_dp
	import cdll_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [REQ_W-1:0] req_type,
	input  logic [VAL_W-1:0] value,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int POS_W  = SLOT_W + 1;

	op_t                     op_q;
	logic [VAL_W-1:0]        val_q;
	status_t                 st_q, st_c;
	logic [SLOT_W-1:0]       head_q, tail_q, cur_q, fhead_q, rem_q, s_q, lnk_q;
	logic signed [POS_W-1:0] pos_q, k_q;
	logic [CNT_W-1:0]        cnt_q, fresh_q;
	logic                    fvalid_q, tvalid_q;
	logic [DATA_WIDTH-1:0]   hv_q, tv_q;
	logic [OUT_W-1:0]        out_q;

	logic                    empty, cdef, full;
	logic [SLOT_W-1:0]       rem_c, s_c;
	logic signed [POS_W-1:0] k_c, last_c;
	logic [CNT_W-1:0]        cnt_m1;

	logic                    nx_we, pv_we, vl_we;
	logic [SLOT_W-1:0]       nx_wa, nx_wd, pv_wa, pv_wd, vl_wa, lnk_ra, vl_ra;
	logic [SLOT_W-1:0]       nx_rd, pv_rd;
	logic [DATA_WIDTH-1:0]   vl_rd, vl_wd;

	function automatic logic [VAL_W-1:0] ext_val(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] t;
		t = 64'(d);
		return t[VAL_W-1:0];
	endfunction

	assign empty  = (cnt_q == '0);
	assign cdef   = !pos_q[POS_W-1];
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign last_c = POS_W'(cnt_m1);
	assign s_c    = fvalid_q ? fhead_q : fresh_q[SLOT_W-1:0];
	assign vl_wd  = DATA_WIDTH'(val_q);

	always_comb begin
		st_c = ST_OK;
		case (op_q)
			OP_PREPEND, OP_APPEND: begin
				if (full) st_c = ST_FULL;
			end
			OP_INS_BEFORE, OP_INS_AFTER: begin
				if (empty) st_c = ST_EMPTY;
				else if (!cdef) st_c = ST_CUR_UNDEF;
				else if (full) st_c = ST_FULL;
			end
			OP_DEL_CURSOR, OP_MV_PREV, OP_MV_NEXT, OP_SET: begin
				if (empty) st_c = ST_EMPTY;
				else if (!cdef) st_c = ST_CUR_UNDEF;
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_MV_FRONT, OP_MV_BACK, OP_CLEAR: begin
				if (empty) st_c = ST_EMPTY;
			end
			default: st_c = ST_OK;
		endcase
	end

	always_comb begin
		case (op_q)
			OP_DEL_CURSOR: begin
				rem_c = cur_q;
				k_c   = pos_q;
			end
			OP_DEL_FRONT: begin
				rem_c = head_q;
				k_c   = '0;
			end
			default: begin
				rem_c = tail_q;
				k_c   = last_c;
			end
		endcase
	end

	assign stat.op     = op_q;
	assign stat.err    = (st_c != ST_OK);
	assign stat.at_end = (op_q == OP_MV_PREV) ? (cur_q == head_q) : (cur_q == tail_q);

	always_comb begin
		case (cmd.lnk_rd)
			LRD_FHEAD: lnk_ra = fhead_q;
			LRD_CUR:   lnk_ra = cur_q;
			default:   lnk_ra = rem_c;
		endcase
		case (cmd.val_rd)
			VRD_HEAD: vl_ra = head_q;
			VRD_TAIL: vl_ra = tail_q;
			default:  vl_ra = cur_q;
		endcase
	end

	// memory write ports
	always_comb begin
		nx_we = 1'b0; nx_wa = s_q; nx_wd = '0;
		pv_we = 1'b0; pv_wa = s_q; pv_wd = '0;
		vl_we = 1'b0; vl_wa = s_c;
		case (cmd.act)
			ACT_DECODE: begin
				if (op_q == OP_SET && st_c == ST_OK) begin
					vl_we = 1'b1;
					vl_wa = cur_q;
				end
			end
			ACT_ALLOC: vl_we = 1'b1;
			ACT_LINK1: begin
				case (op_q)
					OP_PREPEND: begin
						nx_we = 1'b1; nx_wd = head_q;
						pv_we = !empty; pv_wa = head_q; pv_wd = s_q;
					end
					OP_APPEND: begin
						pv_we = 1'b1; pv_wd = tail_q;
						nx_we = !empty; nx_wa = tail_q; nx_wd = s_q;
					end
					OP_INS_BEFORE: begin
						nx_we = 1'b1; nx_wd = cur_q;
						pv_we = 1'b1; pv_wd = pv_rd;
					end
					OP_INS_AFTER: begin
						pv_we = 1'b1; pv_wd = cur_q;
						nx_we = 1'b1; nx_wd = nx_rd;
					end
					default: ;
				endcase
			end
			ACT_LINK2: begin
				if (op_q == OP_INS_BEFORE) begin
					nx_we = (cur_q != head_q); nx_wa = lnk_q; nx_wd = s_q;
					pv_we = 1'b1; pv_wa = cur_q; pv_wd = s_q;
				end else begin
					pv_we = (cur_q != tail_q); pv_wa = lnk_q; pv_wd = s_q;
					nx_we = 1'b1; nx_wa = cur_q; nx_wd = s_q;
				end
			end
			ACT_RM1: begin
				nx_we = (rem_q != head_q); nx_wa = pv_rd; nx_wd = nx_rd;
				pv_we = (rem_q != tail_q); pv_wa = nx_rd; pv_wd = pv_rd;
			end
			ACT_RM2: begin
				nx_we = 1'b1; nx_wa = rem_q; nx_wd = fhead_q;
			end
			default: ;
		endcase
	end

	cdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(lnk_ra), .rdata(nx_rd)
	);

	cdll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(lnk_ra), .rdata(pv_rd)
	);

	cdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd)
	);

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cur_q    <= '0;
			pos_q    <= '1;
			cnt_q    <= '0;
			fresh_q  <= '0;
			fhead_q  <= '0;
			fvalid_q <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			case (cmd.act)
				ACT_DECODE: begin
					if (st_c == ST_OK) begin
						case (op_q)
							OP_MV_FRONT: begin
								cur_q <= head_q;
								pos_q <= '0;
							end
							OP_MV_BACK: begin
								cur_q <= tail_q;
								pos_q <= last_c;
							end
							OP_MV_PREV, OP_MV_NEXT: begin
								if (stat.at_end) begin
									cur_q <= '0;
									pos_q <= '1;
								end
							end
							OP_CLEAR: begin
								head_q   <= '0;
								tail_q   <= '0;
								cur_q    <= '0;
								pos_q    <= '1;
								cnt_q    <= '0;
								fresh_q  <= '0;
								fhead_q  <= '0;
								fvalid_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ACT_ALLOC: begin
					if (fvalid_q) begin
						fhead_q  <= nx_rd;
						fvalid_q <= (fresh_q - cnt_q - CNT_W'(1)) != '0;
					end else begin
						fresh_q <= fresh_q + CNT_W'(1);
					end
				end
				ACT_LINK1: begin
					if (op_q == OP_PREPEND) begin
						head_q <= s_q;
						if (empty) tail_q <= s_q;
						if (cdef) pos_q <= pos_q + POS_W'(1);
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (op_q == OP_APPEND) begin
						tail_q <= s_q;
						if (empty) head_q <= s_q;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ACT_LINK2: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (op_q == OP_INS_BEFORE) begin
						if (cur_q == head_q) head_q <= s_q;
						pos_q <= pos_q + POS_W'(1);
					end else if (cur_q == tail_q) begin
						tail_q <= s_q;
					end
				end
				ACT_RM1: begin
					cnt_q <= cnt_m1;
					// last element gone
					if (cnt_m1 == '0) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (rem_q == head_q) head_q <= nx_rd;
						if (rem_q == tail_q) tail_q <= pv_rd;
					end
					if (cdef) begin
						if (cur_q == rem_q) begin
							cur_q <= '0;
							pos_q <= '1;
						end else if (pos_q > k_q) begin
							pos_q <= pos_q - POS_W'(1);
						end
					end
				end
				ACT_RM2: begin
					fhead_q  <= rem_q;
					fvalid_q <= 1'b1;
				end
				ACT_MOVE: begin
					if (op_q == OP_MV_PREV) begin
						cur_q <= pv_rd;
						pos_q <= pos_q - POS_W'(1);
					end else begin
						cur_q <= nx_rd;
						pos_q <= pos_q + POS_W'(1);
					end
				end
				default: ;
			endcase
			if (cmd.act == ACT_LOAD) tvalid_q <= 1'b1;
			else if (m_tready) tvalid_q <= 1'b0;
		end
	end

	// request payload and result
	always_ff @(posedge clk) begin
		case (cmd.act)
			ACT_LATCH: begin
				op_q  <= op_t'(req_type);
				val_q <= value;
			end
			ACT_DECODE: begin
				st_q  <= st_c;
				rem_q <= rem_c;
				k_q   <= k_c;
			end
			ACT_ALLOC: s_q <= s_c;
			ACT_LINK1: lnk_q <= (op_q == OP_INS_BEFORE) ? pv_rd : nx_rd;
			ACT_CAP_HEAD: hv_q <= vl_rd;
			ACT_CAP_TAIL: tv_q <= vl_rd;
			ACT_LOAD: begin
				out_q <= {4'b0,
					empty ? VAL_W'(0) : ext_val(tv_q),
					empty ? VAL_W'(0) : ext_val(hv_q),
					cdef ? ext_val(vl_rd) : VAL_W'(0),
					LEN_W'(pos_q),
					LEN_W'(cnt_q),
					st_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = out_q;

endmodule

// File: hw/rtl/cursor_doubly_linked_list.sv
// top level of the cursor linked list
//
// A bounded doubly linked list of unsigned words with a cursor. Each request
// (operation code in s_tuser, value in s_tdata) yields one result with the
// status, length, cursor position and the cursor, front and back values.
// A request passes from acceptance to m_tvalid through a decode step, up to
// three steps of link and value memory updates (single write port per
// memory, registered reads), three steps reading the head, tail and cursor
// values, then a step loading the output register, which waits while an
// earlier result is still unaccepted. Requests are handled one at a time;
// a new request is taken while the previous result waits in the output
// register. No clearing pass is needed after reset.
module cursor_doubly_linked_list
	import cdll_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // value
	input  logic [3:0]       s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, list_length, cursor_position, cursor_value, front_value, back_value
	output logic [OUT_W-1:0] m_tdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cdll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_full (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdll_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_type (s_tuser),
		.value    (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// one request in flight at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while one is in progress");

	// an empty list reports zero front and back values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((CAPACITY < 512) && m_tvalid && (m_tdata[10:2] == 9'd0))
			|-> (m_tdata[115:52] == 64'd0))
		else $error("empty list with nonzero end values");

	// an error status leaves the length unchanged
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == ACT_DECODE && stat.err) |=> $stable(u_dp.cnt_q))
		else $error("failed request changed the length");

endmodule
